/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside of reset.
`define WRA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");

// A condition that, once seen, must be followed by another in the next cycle.
`define WRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

/* hw/rtl/wra_pkg.sv */
package wra_pkg;

	localparam int WINDOW   = 4;
	localparam int NBUCKETS = WINDOW + 1;

	localparam int AMOUNT_W = 32;
	localparam int SECOND_W = 32;
	localparam int BUCKET_W = 40;
	localparam int AVG_W    = 46;
	localparam int TOTAL_W  = 48;

	localparam int PTR_W   = (NBUCKETS > 1) ? $clog2(NBUCKETS) : 1;
	localparam int USED_W  = $clog2(NBUCKETS + 1);
	localparam int DIV_W   = $clog2(WINDOW + 1);
	localparam int CARRY_W = $clog2(WINDOW + 1);
	localparam int COL_W   = CARRY_W + 1;
	localparam int CNT_W   = $clog2(TOTAL_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_LOAD,
		ST_DIVIDE,
		ST_DONE
	} wra_state_t;

	typedef struct packed {
		logic             start;
		logic             step;
		logic [CNT_W-1:0] cnt;
	} acc_ctrl_t;

	typedef struct packed {
		logic [AVG_W-1:0]   sum;
		logic [TOTAL_W-1:0] total;
		logic [USED_W-1:0]  used;
	} acc_stat_t;

	typedef struct packed {
		logic start;
		logic step;
	} div_ctrl_t;

endpackage

/* hw/rtl/wra_in_if.sv */
interface wra_in_if;
	import wra_pkg::*;

	logic                valid;
	logic                ready;
	logic [AMOUNT_W-1:0] sample_amount;
	logic [SECOND_W-1:0] now_second;

	modport source (output valid, output sample_amount, output now_second, input ready);
	modport sink (input valid, input sample_amount, input now_second, output ready);

endinterface

/* hw/rtl/wra_out_if.sv */
interface wra_out_if;
	import wra_pkg::*;

	logic               valid;
	logic               ready;
	logic [AVG_W-1:0]   average;
	logic [TOTAL_W-1:0] running_total;

	modport source (output valid, output average, output running_total, input ready);
	modport sink (input valid, input average, input running_total, output ready);

endinterface

/* hw/rtl/wra_accum.sv */
`include "assert_macros.svh"

// Bucket ring with bit-serial update: all buckets and the running total
// rotate one bit per step, the current bucket and the total take a serial
// add of the amount, and the other buckets are summed column by column.
module wra_accum (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wra_pkg::acc_ctrl_t           ctrl,
	input  logic [wra_pkg::AMOUNT_W-1:0] amount,
	input  logic [wra_pkg::SECOND_W-1:0] now,
	output wra_pkg::acc_stat_t           stat
);
	import wra_pkg::*;

	logic [BUCKET_W-1:0] bucket_q [NBUCKETS];
	logic [PTR_W-1:0]    ptr_q;
	logic [USED_W-1:0]   used_q;
	logic [SECOND_W-1:0] last_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [AVG_W-1:0]    sum_q;
	logic [AMOUNT_W-1:0] amt_q;
	logic                carry_b_q;
	logic                carry_t_q;
	logic [CARRY_W-1:0]  col_carry_q;

	logic             new_sec;
	logic [PTR_W-1:0] ptr_nx;
	logic             in_bucket;
	logic             in_sum;
	logic             add_a;
	logic             bsum;
	logic             bcout;
	logic             tsum;
	logic             tcout;
	logic [COL_W-1:0] col;

	assign new_sec   = (used_q == '0) || (now != last_q);
	assign ptr_nx    = (ptr_q == PTR_W'(NBUCKETS - 1)) ? '0 : ptr_q + PTR_W'(1);
	assign in_bucket = ctrl.cnt < CNT_W'(BUCKET_W);
	assign in_sum    = ctrl.cnt < CNT_W'(AVG_W);

	assign add_a = bucket_q[ptr_q][0];
	assign bsum  = add_a ^ amt_q[0] ^ carry_b_q;
	assign bcout = (add_a & amt_q[0]) | (add_a & carry_b_q) | (amt_q[0] & carry_b_q);
	assign tsum  = total_q[0] ^ amt_q[0] ^ carry_t_q;
	assign tcout = (total_q[0] & amt_q[0]) | (total_q[0] & carry_t_q) |
		(amt_q[0] & carry_t_q);

	// Column sum over the buckets other than the current one.
	always_comb begin
		col = COL_W'(col_carry_q);
		for (int k = 0; k < NBUCKETS; k++) begin
			if (in_bucket && (PTR_W'(k) != ptr_q)) begin
				col = col + COL_W'(bucket_q[k][0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NBUCKETS; k++) begin
				bucket_q[k] <= '0;
			end
			ptr_q   <= '0;
			used_q  <= '0;
			last_q  <= '0;
			total_q <= '0;
		end else if (ctrl.start) begin
			if (new_sec) begin
				ptr_q  <= ptr_nx;
				last_q <= now;
				if (used_q < USED_W'(NBUCKETS)) begin
					used_q <= used_q + USED_W'(1);
				end
				bucket_q[ptr_nx] <= '0;
			end
		end else if (ctrl.step) begin
			total_q <= {tsum, total_q[TOTAL_W-1:1]};
			if (in_bucket) begin
				for (int k = 0; k < NBUCKETS; k++) begin
					if (PTR_W'(k) == ptr_q) begin
						// The final carry out means the bucket has overflowed.
						if ((ctrl.cnt == CNT_W'(BUCKET_W - 1)) && bcout) begin
							bucket_q[k] <= '1;
						end else begin
							bucket_q[k] <= {bsum, bucket_q[k][BUCKET_W-1:1]};
						end
					end else begin
						bucket_q[k] <= {bucket_q[k][0], bucket_q[k][BUCKET_W-1:1]};
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			amt_q       <= amount;
			carry_b_q   <= 1'b0;
			carry_t_q   <= 1'b0;
			col_carry_q <= '0;
		end else if (ctrl.step) begin
			amt_q       <= {1'b0, amt_q[AMOUNT_W-1:1]};
			carry_b_q   <= bcout;
			carry_t_q   <= tcout;
			col_carry_q <= col[COL_W-1:1];
			if (in_sum) begin
				sum_q <= {col[0], sum_q[AVG_W-1:1]};
			end
		end
	end

	assign stat.sum   = sum_q;
	assign stat.total = total_q;
	assign stat.used  = used_q;

	`WRA_ASSERT(a_ptr_range, clk, arst_n, {1'b0, ptr_q} < (PTR_W + 1)'(NBUCKETS))
	`WRA_ASSERT(a_used_range, clk, arst_n, used_q <= USED_W'(NBUCKETS))
	`WRA_ASSERT(a_fresh_ptr, clk, arst_n, used_q != '0 || ptr_q == '0)

endmodule

/* hw/rtl/wra_div.sv */
`include "assert_macros.svh"

// Restoring divider, one quotient bit per step, dividend shifted out MSB first.
module wra_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wra_pkg::div_ctrl_t        ctrl,
	input  logic [wra_pkg::AVG_W-1:0] dividend,
	input  logic [wra_pkg::DIV_W-1:0] divisor,
	output logic [wra_pkg::AVG_W-1:0] quotient
);
	import wra_pkg::*;

	logic [AVG_W-1:0] q_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] d_q;

	logic [DIV_W:0] trial;
	logic [DIV_W:0] diff;
	logic           ge;

	assign trial = {rem_q, q_q[AVG_W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			d_q   <= '0;
		end else if (ctrl.start) begin
			rem_q <= '0;
			d_q   <= divisor;
		end else if (ctrl.step) begin
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			q_q <= dividend;
		end else if (ctrl.step) begin
			q_q <= {q_q[AVG_W-2:0], ge};
		end
	end

	assign quotient = q_q;

	`WRA_ASSERT(a_rem_below_divisor, clk, arst_n, d_q == '0 || rem_q < d_q)

endmodule

/* hw/rtl/windowed_rate_average_core.sv */
// One beat is taken at a time: the next is accepted only after the 48-step
// bit-serial bucket and total pass and the 46-step restoring divider have
// run and the result has been handed to the output register.
// A finished result waits in the output register while the next beat is taken.
// Reset (arst_n low, asynchronous) clears all buckets, the ring pointer, the fill
// count, the last second and the running total.
`include "assert_macros.svh"

module windowed_rate_average_core (
	input  logic             clk,
	input  logic             arst_n,
	wra_in_if.sink           sample,
	wra_out_if.source        result
);
	import wra_pkg::*;

	// Control sequencing. One beat is processed at a time: an accumulate pass
	// in which every bucket rotates a full turn one bit per cycle, a load of
	// the divider, the divide itself, and a hand-off to the output register.
	wra_state_t       state_q;
	wra_state_t       state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic             load_out;

	acc_ctrl_t acc_ctrl;
	acc_stat_t acc_stat;
	div_ctrl_t div_ctrl;

	logic [DIV_W-1:0] divisor;
	logic [AVG_W-1:0] quotient;

	logic               out_valid_q;
	logic [AVG_W-1:0]   out_avg_q;
	logic [TOTAL_W-1:0] out_total_q;

	// The bucket ring, the running total and the serial column adder that
	// forms the sum of the completed buckets.
	wra_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (acc_ctrl),
		.amount (sample.sample_amount),
		.now    (sample.now_second),
		.stat   (acc_stat)
	);

	// The divisor is the fill count minus one, never below one, so with two
	// buckets in use the sum passes through unchanged.
	assign divisor = (acc_stat.used > USED_W'(1)) ?
		DIV_W'(acc_stat.used - USED_W'(1)) : DIV_W'(1);

	wra_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (acc_stat.sum),
		.divisor  (divisor),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		acc_ctrl       = '0;
		acc_ctrl.cnt   = cnt_q;
		div_ctrl       = '0;
		load_out       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (sample.valid) begin
					acc_ctrl.start = 1'b1;
					state_d        = ST_ACCUM;
				end
			end
			ST_ACCUM: begin
				acc_ctrl.step = 1'b1;
				cnt_d         = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(TOTAL_W - 1)) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				div_ctrl.start = 1'b1;
				cnt_d          = '0;
				state_d        = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				div_ctrl.step = 1'b1;
				cnt_d         = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(AVG_W - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// Hand the result over as soon as the output register is free.
				if (!out_valid_q || result.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign sample.ready = (state_q == ST_IDLE);

	// Output register. It holds a finished beat until the sink takes it, which
	// lets the core go back and accept the next input beat meanwhile.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The average stays zero until a completed bucket exists.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_avg_q   <= (acc_stat.used > USED_W'(1)) ? quotient : '0;
			out_total_q <= acc_stat.total;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.average       = out_avg_q;
	assign result.running_total = out_total_q;

	`WRA_ASSERT_NEXT(a_accept_starts, clk, arst_n, sample.valid && sample.ready, state_q == ST_ACCUM && cnt_q == '0)
	`WRA_ASSERT_NEXT(a_done_loads, clk, arst_n, load_out, result.valid)
	`WRA_ASSERT(a_div_count, clk, arst_n, state_q != ST_DIVIDE || cnt_q < CNT_W'(AVG_W))

endmodule
